### rtl/slpa_pkg.sv
// slpa_pkg: shared types and constants for the sensor line parser
// holds the item structs, opcode codes, character codes and the prefix table
// depends on nothing
package slpa_pkg;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_START = 8'h50;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int unsigned PREFIX_LEN = 4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_sum;
    logic [15:0] sample_count;
    logic [15:0] zero_count;
    logic        line_scored;
    logic [15:0] last_reading;
    logic        sync_lost;
  } out_item_t;

  // what one byte did to the open line
  typedef struct packed {
    logic        score;
    logic [15:0] reading;
    logic        lost;
  } line_evt_t;

  // expected text "PM: " at line positions 0 to 3
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h50;
      2'd1: ch = 8'h4D;
      2'd2: ch = 8'h3A;
      2'd3: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/slpa_parse.sv
// slpa_parse: line assembly state (position, prefix match, digit accumulator)
// reports per item whether the line was scored or dropped
// depends on slpa_pkg
module slpa_parse #(
  parameter int unsigned MAX_LINE_LEN = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  slpa_pkg::in_item_t  item,
  output slpa_pkg::line_evt_t evt
);

  localparam int unsigned POS_W = $clog2(MAX_LINE_LEN + 2);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pm_r, pm_nxt;
  logic [15:0]      rd_r, rd_nxt;
  logic [7:0]       ch;
  logic [7:0]       dig;

  assign ch  = item.rx_byte;
  assign dig = ch - slpa_pkg::CH_ZERO;

  always_comb begin
    pos_nxt = pos_r;
    pm_nxt  = pm_r;
    rd_nxt  = rd_r;
    evt     = '0;
    if (item.opcode == slpa_pkg::OP_BYTE && ch != slpa_pkg::CH_NUL) begin
      if (ch == slpa_pkg::CH_CR) begin
        if (pos_r >= POS_W'(slpa_pkg::PREFIX_LEN) && pm_r) begin
          evt.score   = 1'b1;
          evt.reading = rd_r;
        end
        pos_nxt = '0;
        pm_nxt  = 1'b0;
        rd_nxt  = '0;
      end else if (ch == slpa_pkg::CH_START) begin
        pos_nxt = POS_W'(1);
        pm_nxt  = 1'b1;
        rd_nxt  = '0;
      end else if (pos_r != '0) begin
        if (pos_r < POS_W'(slpa_pkg::PREFIX_LEN) && ch != slpa_pkg::prefix_char(pos_r[1:0]))
          pm_nxt = 1'b0;
        if (ch >= slpa_pkg::CH_ZERO && ch <= slpa_pkg::CH_NINE)
          // times ten as two shifts, wraps at 16 bits
          rd_nxt = {rd_r[12:0], 3'b000} + {rd_r[14:0], 1'b0} + {12'd0, dig[3:0]};
        pos_nxt = pos_r + POS_W'(1);
      end
      if (ch == slpa_pkg::CH_STAR || pos_nxt > POS_W'(MAX_LINE_LEN)) begin
        evt.lost = 1'b1;
        pos_nxt  = '0;
        pm_nxt   = 1'b0;
        rd_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      pm_r  <= 1'b0;
      rd_r  <= '0;
    end else if (adv) begin
      pos_r <= pos_nxt;
      pm_r  <= pm_nxt;
      rd_r  <= rd_nxt;
    end
  end

endmodule

### rtl/slpa_accum.sv
// slpa_accum: running totals (sum of readings, sample and zero counts)
// updates from the parser's line events and the clear opcode
// depends on slpa_pkg
module slpa_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                clear,
  input  slpa_pkg::line_evt_t evt,
  output logic [31:0]         sum_nxt,
  output logic [15:0]         cnt_nxt,
  output logic [15:0]         zero_nxt
);

  logic [31:0] sum_r;
  logic [15:0] cnt_r;
  logic [15:0] zero_r;

  always_comb begin
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    if (clear) begin
      sum_nxt  = '0;
      cnt_nxt  = '0;
      zero_nxt = '0;
    end else if (evt.score) begin
      if (evt.reading != 16'd0)
        sum_nxt = sum_r + {16'd0, evt.reading};
      else
        zero_nxt = zero_r + 16'd1;
      cnt_nxt = cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      zero_r <= '0;
    end else if (adv) begin
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      zero_r <= zero_nxt;
    end
  end

endmodule

### rtl/sensor_line_parse_accumulate.sv
// sensor_line_parse_accumulate: top level, input register, parser, totals, result register
// depends on slpa_pkg, slpa_parse, slpa_accum
//
//   channel | direction | ports                          | payload
//   in      | input     | in_valid, in_ready, in_data    | slpa_pkg::in_item_t
//   out     | output    | out_valid, out_ready, out_data | slpa_pkg::out_item_t
//
// one item per cycle unless out_ready stalls; path: input register, then result register
// line state and totals update when an item moves from the input register to the result
// register, through one add of the 32-bit sum
// reset (rst_n low, synchronous) empties both registers and clears line state and totals
// a stalled result holds; the input register takes one more item, then in_ready stays low
// until the result is taken
module sensor_line_parse_accumulate #(
  parameter int unsigned MAX_LINE_LEN = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slpa_pkg::out_item_t out_data
);

  logic                 in_valid_r;
  slpa_pkg::in_item_t   in_item_r;
  logic                 out_valid_r;
  slpa_pkg::out_item_t  out_item_r;
  logic                 adv;
  slpa_pkg::line_evt_t  evt;
  logic [31:0]          sum_nxt;
  logic [15:0]          cnt_nxt;
  logic [15:0]          zero_nxt;

  // item moves on when the result register is free or being emptied
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  slpa_parse #(
    .MAX_LINE_LEN(MAX_LINE_LEN)
  ) u_parse (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .item (in_item_r),
    .evt  (evt)
  );

  slpa_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .clear   (in_item_r.opcode == slpa_pkg::OP_CLEAR),
    .evt     (evt),
    .sum_nxt (sum_nxt),
    .cnt_nxt (cnt_nxt),
    .zero_nxt(zero_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)
        in_valid_r <= in_valid;
      if (adv)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      in_item_r <= in_data;
    if (adv) begin
      out_item_r.total_sum    <= sum_nxt;
      out_item_r.sample_count <= cnt_nxt;
      out_item_r.zero_count   <= zero_nxt;
      out_item_r.line_scored  <= evt.score;
      out_item_r.last_reading <= evt.reading;
      out_item_r.sync_lost    <= evt.lost;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

### rtl/slpa_checker.sv
// slpa_checker: port-level assertions for sensor_line_parse_accumulate
// bound to the top level; depends on slpa_pkg
module slpa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input slpa_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input slpa_pkg::out_item_t out_data
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an item never reports a line as both scored and dropped
  a_score_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.line_scored && out_data.sync_lost))
    else $error("item both scored and dropped");

  a_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.line_scored |-> out_data.last_reading == 16'd0)
    else $error("reading shown without a scored line");

endmodule

bind sensor_line_parse_accumulate slpa_checker u_slpa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
